// ===== design/bptc_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants, operation codes and controller/datapath
// command types for the barometric compensation core. No dependencies.
package bptc_pkg;

	// Port widths
	localparam int RAW_W = 24;
	localparam int CFG_W = 24;
	localparam int IDX_W = 3;
	localparam int PRS_W = 28;
	localparam int TMP_W = 18;

	// Shared multiplier: A operand times B operand, B taken in two halves
	localparam int A_W  = 29;
	localparam int B_W  = 44;
	localparam int BL_W = 22;
	localparam int BH_W = B_W - BL_W;
	localparam int P_W  = A_W + B_W;

	// Reciprocals for the oversampling scale, 2^32 / 62 and 2^32 / 14
	localparam int RECIP_SH = 32;
	localparam logic signed [B_W-1:0] RECIP_62 = 44'sd69273666;
	localparam logic signed [B_W-1:0] RECIP_14 = 44'sd306783378;
	localparam int R_W = A_W + 2;

	// Datapath register widths, sized to the value ranges
	localparam int X_W     = 23;
	localparam int Y_W     = 23;
	localparam int A_REG_W = 38;
	localparam int B_REG_W = 43;
	localparam int S_W     = 48;
	localparam int T_W     = 34;
	localparam int PS_W    = S_W + 1;
	localparam int TS_W    = T_W + 1;

	localparam logic signed [PRS_W-1:0] PRS_MAX = {1'b0, {(PRS_W-1){1'b1}}};
	localparam logic signed [PRS_W-1:0] PRS_MIN = {1'b1, {(PRS_W-1){1'b0}}};
	localparam logic signed [TMP_W-1:0] TMP_MAX = {1'b0, {(TMP_W-1){1'b1}}};
	localparam logic signed [TMP_W-1:0] TMP_MIN = {1'b1, {(TMP_W-1){1'b0}}};

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_P_OFFSET = 3'd0;
	localparam logic [IDX_W-1:0] REG_P_LINEAR = 3'd1;
	localparam logic [IDX_W-1:0] REG_P_SQUARE = 3'd2;
	localparam logic [IDX_W-1:0] REG_P_CUBE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_T_TERM   = 3'd4;
	localparam logic [IDX_W-1:0] REG_X_LINEAR = 3'd5;
	localparam logic [IDX_W-1:0] REG_X_SQUARE = 3'd6;
	localparam logic [IDX_W-1:0] REG_T_COEFS  = 3'd7;

	// Polynomial steps in evaluation order
	typedef enum logic [3:0] {
		OP_X,	// scaled pressure
		OP_Y,	// scaled temperature
		OP_A,	// c20 + x*c30
		OP_B,	// c10 + x*a
		OP_S,	// c00 + x*b
		OP_E,	// c11 + x*c21
		OP_F,	// c01 + x*e
		OP_G,	// s + y*f
		OP_T	// c0/2 + c1*y
	} op_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic wb;
		logic finish;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} stat_t;

	// Steps whose B operand fits the low half take one multiplier pass
	function automatic logic op_single(op_t op);
		return (op == OP_A) || (op == OP_E) || (op == OP_T);
	endfunction

endpackage

// ===== design/bptc_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with accumulator: one or two partial products.
// Depends on bptc_pkg.
module bptc_mul (
	input  logic                          clk,
	input  logic                          lo,
	input  logic                          hi,
	input  logic                          single,
	input  logic signed [bptc_pkg::A_W-1:0] a,
	input  logic signed [bptc_pkg::B_W-1:0] b,
	output logic signed [bptc_pkg::P_W-1:0] acc
);
	import bptc_pkg::*;

	logic signed [BL_W:0]        b_lo_ext;
	logic signed [BH_W-1:0]      b_hi;
	logic signed [A_W+BL_W:0]    p_lo;
	logic signed [A_W+BH_W-1:0]  p_hi;
	logic signed [P_W-1:0]       acc_q;

	// low half is unsigned in a split product, signed when it is the whole operand
	assign b_lo_ext = single ? {b[BL_W-1], b[BL_W-1:0]} : {1'b0, b[BL_W-1:0]};
	assign b_hi     = b[B_W-1:BL_W];
	assign p_lo     = a * b_lo_ext;
	assign p_hi     = a * b_hi;

	always_ff @(posedge clk) begin
		if (lo) begin
			acc_q <= P_W'(p_lo);
		end else if (hi) begin
			acc_q <= acc_q + {p_hi, {BL_W{1'b0}}};
		end
	end

	assign acc = acc_q;

endmodule

// ===== design/bptc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: calibration registers, held temperature, operand select,
// write-back of each polynomial step, rounding, saturation and result register.
// Depends on bptc_pkg and bptc_mul.
module bptc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bptc_pkg::cmd_t                    cmd,
	output bptc_pkg::stat_t                   stat,
	input  logic                              cfg_we,
	input  logic [bptc_pkg::IDX_W-1:0]        cfg_index,
	input  logic [bptc_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              temp_ready,
	input  logic signed [bptc_pkg::RAW_W-1:0] temp_raw,
	input  logic signed [bptc_pkg::RAW_W-1:0] pressure_raw,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic signed [bptc_pkg::PRS_W-1:0] pressure_comp,
	output logic signed [bptc_pkg::TMP_W-1:0] temperature_comp,
	output logic                              saturated
);
	import bptc_pkg::*;

	logic signed [19:0]      c00_q, c10_q;
	logic signed [15:0]      c20_q, c30_q, c01_q, c11_q, c21_q;
	logic [23:0]             tcoef_q;
	logic signed [11:0]      c0, c1;
	logic signed [RAW_W-1:0] held_q, p_q;

	logic signed [X_W-1:0]     x_q;
	logic signed [Y_W-1:0]     y_q;
	logic signed [A_REG_W-1:0] a_q;	// a, then e
	logic signed [B_REG_W-1:0] b_q;	// b, then f
	logic signed [S_W-1:0]     s_q;
	logic signed [T_W-1:0]     t_q;

	logic signed [A_W-1:0] n_val, m_val, mul_a;
	logic signed [B_W-1:0] mul_b;
	logic signed [P_W-1:0] acc, rnd16, rnd20;

	logic signed [X_W-1:0] q0x, x_next;
	logic signed [Y_W-1:0] q0y, y_next;
	logic signed [R_W-1:0] rx, ry;

	logic signed [PS_W-1:0] ps;
	logic signed [TS_W-1:0] ts;
	logic                   p_hi_clip, p_lo_clip, t_hi_clip, t_lo_clip;
	logic signed [PRS_W-1:0] p_sat;
	logic signed [TMP_W-1:0] t_sat;

	logic                    out_valid_q, sat_q;
	logic signed [PRS_W-1:0] prs_q;
	logic signed [TMP_W-1:0] tmp_q;

	assign c0 = tcoef_q[23:12];
	assign c1 = tcoef_q[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c00_q   <= '0;
			c10_q   <= '0;
			c20_q   <= '0;
			c30_q   <= '0;
			c01_q   <= '0;
			c11_q   <= '0;
			c21_q   <= '0;
			tcoef_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_P_OFFSET: c00_q   <= cfg_data[19:0];
				REG_P_LINEAR: c10_q   <= cfg_data[19:0];
				REG_P_SQUARE: c20_q   <= cfg_data[15:0];
				REG_P_CUBE:   c30_q   <= cfg_data[15:0];
				REG_T_TERM:   c01_q   <= cfg_data[15:0];
				REG_X_LINEAR: c11_q   <= cfg_data[15:0];
				REG_X_SQUARE: c21_q   <= cfg_data[15:0];
				REG_T_COEFS:  tcoef_q <= cfg_data[23:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.load && temp_ready) begin
			held_q <= temp_raw;
		end
	end

	// numerators of the oversampling scale: 16p + 31 over 62, 4t + 7 over 14
	assign n_val = (A_W'(p_q) <<< 4) + A_W'(31);
	assign m_val = (A_W'(held_q) <<< 2) + A_W'(7);

	always_comb begin
		mul_a = A_W'(x_q);
		mul_b = RECIP_62;
		unique case (cmd.op)
			OP_X: begin mul_a = n_val;        mul_b = RECIP_62;      end
			OP_Y: begin mul_a = m_val;        mul_b = RECIP_14;      end
			OP_A: begin mul_a = A_W'(x_q);    mul_b = B_W'(c30_q);   end
			OP_B: begin mul_a = A_W'(x_q);    mul_b = B_W'(a_q);     end
			OP_S: begin mul_a = A_W'(x_q);    mul_b = B_W'(b_q);     end
			OP_E: begin mul_a = A_W'(x_q);    mul_b = B_W'(c21_q);   end
			OP_F: begin mul_a = A_W'(x_q);    mul_b = B_W'(a_q);     end
			OP_G: begin mul_a = A_W'(y_q);    mul_b = B_W'(b_q);     end
			OP_T: begin mul_a = A_W'(y_q);    mul_b = B_W'(c1);      end
			default: begin mul_a = A_W'(x_q); mul_b = RECIP_62;      end
		endcase
	end

	bptc_mul u_mul (
		.clk    (clk),
		.lo     (cmd.mul_lo),
		.hi     (cmd.mul_hi),
		.single (op_single(cmd.op)),
		.a      (mul_a),
		.b      (mul_b),
		.acc    (acc)
	);

	assign rnd16 = (acc + (P_W'(1) <<< 15)) >>> 16;
	assign rnd20 = (acc + (P_W'(1) <<< 19)) >>> 20;

	// reciprocal quotient is off by at most one: fix it from the remainder
	assign q0x = acc[RECIP_SH+X_W-1:RECIP_SH];
	assign rx  = R_W'(n_val) - ((R_W'(q0x) <<< 6) - (R_W'(q0x) <<< 1));
	always_comb begin
		priority if (rx < 0) begin
			x_next = q0x - X_W'(1);
		end else if (rx >= R_W'(62)) begin
			x_next = q0x + X_W'(1);
		end else begin
			x_next = q0x;
		end
	end

	assign q0y = acc[RECIP_SH+Y_W-1:RECIP_SH];
	assign ry  = R_W'(m_val) - ((R_W'(q0y) <<< 4) - (R_W'(q0y) <<< 1));
	always_comb begin
		priority if (ry < 0) begin
			y_next = q0y - Y_W'(1);
		end else if (ry >= R_W'(14)) begin
			y_next = q0y + Y_W'(1);
		end else begin
			y_next = q0y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q <= pressure_raw;
		end
		if (cmd.wb) begin
			unique case (cmd.op)
				OP_X: x_q <= x_next;
				OP_Y: y_q <= y_next;
				OP_A: a_q <= (A_REG_W'(c20_q) <<< 16) + A_REG_W'(acc);
				OP_B: b_q <= (B_REG_W'(c10_q) <<< 16) + B_REG_W'(rnd16);
				OP_S: s_q <= (S_W'(c00_q) <<< 16) + S_W'(rnd16);
				OP_E: a_q <= (A_REG_W'(c11_q) <<< 16) + A_REG_W'(acc);
				OP_F: b_q <= (B_REG_W'(c01_q) <<< 16) + B_REG_W'(rnd16);
				OP_G: s_q <= s_q + S_W'(rnd20);
				OP_T: t_q <= (T_W'(c0) <<< 19) + T_W'(acc);
				default: t_q <= t_q;
			endcase
		end
	end

	// round to Q4 and Q6, then clip
	assign ps = (PS_W'(s_q) + PS_W'(2048)) >>> 12;
	assign ts = (TS_W'(t_q) + TS_W'(8192)) >>> 14;

	assign p_hi_clip = ps > PS_W'(PRS_MAX);
	assign p_lo_clip = ps < PS_W'(PRS_MIN);
	assign t_hi_clip = ts > TS_W'(TMP_MAX);
	assign t_lo_clip = ts < TS_W'(TMP_MIN);

	always_comb begin
		priority if (p_hi_clip) begin
			p_sat = PRS_MAX;
		end else if (p_lo_clip) begin
			p_sat = PRS_MIN;
		end else begin
			p_sat = ps[PRS_W-1:0];
		end
		priority if (t_hi_clip) begin
			t_sat = TMP_MAX;
		end else if (t_lo_clip) begin
			t_sat = TMP_MIN;
		end else begin
			t_sat = ts[TMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			prs_q <= p_sat;
			tmp_q <= t_sat;
			sat_q <= p_hi_clip || p_lo_clip || t_hi_clip || t_lo_clip;
		end
	end

	assign stat.out_full    = out_valid_q;
	assign out_valid        = out_valid_q;
	assign pressure_comp    = prs_q;
	assign temperature_comp = tmp_q;
	assign saturated        = sat_q;

endmodule

// ===== design/bptc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: takes an item, steps the shared multiplier through the
// polynomial one operation at a time and hands the result over. Depends on bptc_pkg.
module bptc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            pressure_ready,
	input  logic            out_ready,
	input  bptc_pkg::stat_t stat,
	output logic            in_ready,
	output bptc_pkg::cmd_t  cmd
);
	import bptc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LO   = 3'd1;
	localparam logic [2:0] S_HI   = 3'd2;
	localparam logic [2:0] S_WB   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	op_t        op_q, op_d;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cmd     = '0;
		cmd.op  = op_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				// a temperature-only poll ends here
				if (in_valid && pressure_ready) begin
					state_d = S_LO;
					op_d    = OP_X;
				end
			end
			S_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = op_single(op_q) ? S_WB : S_HI;
			end
			S_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_WB;
			end
			S_WB: begin
				cmd.wb = 1'b1;
				if (op_q == OP_T) begin
					state_d = S_FIN;
				end else begin
					op_d    = op_t'(op_q + 4'd1);
					state_d = S_LO;
				end
			end
			S_FIN: begin
				// hold until the result register is free
				if (!stat.out_full || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_X;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && pressure_ready |=> state_q == S_LO && op_q == OP_X)
		else $error("pressure item did not start the polynomial");

	a_poll: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !pressure_ready |=> in_ready)
		else $error("temperature-only item left the controller busy");

	a_hi: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HI |-> !op_single(op_q))
		else $error("second partial product on a single-pass step");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && stat.out_full && !out_ready |=> state_q == S_FIN && !cmd.load)
		else $error("result overwrote an item still waiting");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB && op_q != OP_T |=> op_q == op_t'($past(op_q) + 4'd1))
		else $error("polynomial step skipped");

endmodule

// ===== design/baro_pressure_temp_compensate_core.sv =====
`timescale 1ns / 1ps
// Barometric pressure and temperature compensation core.
// Usage:
//   Input channel (in_valid/in_ready) carries one sensor poll: temp_ready,
//   temp_raw, pressure_ready, pressure_raw. A ready temperature is stored on
//   acceptance; a poll with pressure_ready low gives no result and leaves the core idle.
//   A poll with pressure ready runs the calibration polynomial on one shared
//   split multiplier: two reciprocal scalings and seven polynomial steps, each
//   with a low partial product, a high one for wide operands only, and a write-back,
//   then a finish state that rounds, clips and loads the output register. The next
//   item is taken only after the finish state, so a pressure item is not accepted
//   until the previous one has been written to the output register.
//   Output channel (out_valid/out_ready) carries pressure_comp (Q4 Pa),
//   temperature_comp (Q6 C) and saturated. A waiting result does not block the
//   next item; a finished result waits only if the previous one was not taken.
//   Configuration: cfg_we writes cfg_data to register cfg_index at once; write
//   only while idle.
//   Reset clears coefficients, the held temperature and the output valid flag.
// Depends on bptc_pkg, bptc_ctrl, bptc_datapath.
module baro_pressure_temp_compensate_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              temp_ready,
	input  logic signed [bptc_pkg::RAW_W-1:0] temp_raw,
	input  logic                              pressure_ready,
	input  logic signed [bptc_pkg::RAW_W-1:0] pressure_raw,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [bptc_pkg::PRS_W-1:0] pressure_comp,
	output logic signed [bptc_pkg::TMP_W-1:0] temperature_comp,
	output logic                              saturated,
	input  logic                              cfg_we,
	input  logic [bptc_pkg::IDX_W-1:0]        cfg_index,
	input  logic [bptc_pkg::CFG_W-1:0]        cfg_data
);
	import bptc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bptc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.pressure_ready (pressure_ready),
		.out_ready      (out_ready),
		.stat           (stat),
		.in_ready       (in_ready),
		.cmd            (cmd)
	);

	bptc_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.temp_ready       (temp_ready),
		.temp_raw         (temp_raw),
		.pressure_raw     (pressure_raw),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.pressure_comp    (pressure_comp),
		.temperature_comp (temperature_comp),
		.saturated        (saturated)
	);

endmodule

// ===== verif/baro_pressure_temp_compensate_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for baro_pressure_temp_compensate_core: random and directed polls,
// a bit-exact fixed-point predictor, and random stalls on both channels.
// Depends on bptc_pkg and the core.
module baro_pressure_temp_compensate_core_test;
	import bptc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
	localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};

	typedef struct packed {
		logic                    t_rdy;
		logic signed [RAW_W-1:0] t_raw;
		logic                    p_rdy;
		logic signed [RAW_W-1:0] p_raw;
	} poll_t;

	typedef struct packed {
		logic signed [PRS_W-1:0] prs;
		logic signed [TMP_W-1:0] tmp;
		logic                    sat;
	} comp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic temp_ready = 1'b0;
	logic signed [RAW_W-1:0] temp_raw = '0;
	logic pressure_ready = 1'b0;
	logic signed [RAW_W-1:0] pressure_raw = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [PRS_W-1:0] pressure_comp;
	logic signed [TMP_W-1:0] temperature_comp;
	logic saturated;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	baro_pressure_temp_compensate_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.temp_ready(temp_ready), .temp_raw(temp_raw),
		.pressure_ready(pressure_ready), .pressure_raw(pressure_raw),
		.out_valid(out_valid), .out_ready(out_ready),
		.pressure_comp(pressure_comp), .temperature_comp(temperature_comp),
		.saturated(saturated),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Coefficient copy and held temperature of the predictor
	logic signed [19:0] k_p_offset = '0, k_p_linear = '0;
	logic signed [15:0] k_p_square = '0, k_p_cube = '0, k_t_term = '0;
	logic signed [15:0] k_x_linear = '0, k_x_square = '0;
	logic [23:0] k_t_coefs = '0;
	logic signed [RAW_W-1:0] held_temp = '0;

	poll_t poll_q[$];
	comp_t comp_q[$];
	logic [CFG_W-1:0] coef_set [8];

	int polls_queued = 0, polls_taken = 0, results_seen = 0, sat_seen = 0;
	int mismatches = 0, cycle_count = 0;
	int tx_idle_pct = 27, rx_idle_pct = 27;
	logic rx_hold = 1'b0;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d predictions pending",
				cycle_count, comp_q.size());
			$display("** baro_pressure_temp_compensate_core: FAILED **");
			$finish;
		end
	end

	task automatic flag(input string msg);
		$display("MISMATCH t=%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) < 0)
			q--;
		return q;
	endfunction

	// Round to nearest, ties toward +inf
	function automatic longint round_shr(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic comp_t compensate(logic signed [RAW_W-1:0] t_held,
			logic signed [RAW_W-1:0] p_in);
		longint c00, c10, c20, c30, c01, c11, c21, c0, c1;
		longint x, y, a, b, s, e, f, pq, tq;
		comp_t r;
		c00 = longint'(k_p_offset);
		c10 = longint'(k_p_linear);
		c20 = longint'(k_p_square);
		c30 = longint'(k_p_cube);
		c01 = longint'(k_t_term);
		c11 = longint'(k_x_linear);
		c21 = longint'(k_x_square);
		c0 = longint'($signed(k_t_coefs[23:12]));
		c1 = longint'($signed(k_t_coefs[11:0]));
		x = floor_div(16 * longint'(p_in) + 31, 62);
		y = floor_div(4 * longint'(t_held) + 7, 14);
		a = c20 * 65536 + x * c30;
		b = c10 * 65536 + round_shr(x * a, 16);
		s = c00 * 65536 + round_shr(x * b, 16);
		e = c11 * 65536 + x * c21;
		f = c01 * 65536 + round_shr(x * e, 16);
		s = s + round_shr(y * f, 20);
		pq = round_shr(s, 12);
		tq = round_shr(c0 * 524288 + c1 * y, 14);
		r.sat = 1'b0;
		if (pq > longint'(PRS_MAX)) begin
			pq = longint'(PRS_MAX);
			r.sat = 1'b1;
		end else if (pq < longint'(PRS_MIN)) begin
			pq = longint'(PRS_MIN);
			r.sat = 1'b1;
		end
		if (tq > longint'(TMP_MAX)) begin
			tq = longint'(TMP_MAX);
			r.sat = 1'b1;
		end else if (tq < longint'(TMP_MIN)) begin
			tq = longint'(TMP_MIN);
			r.sat = 1'b1;
		end
		r.prs = pq[PRS_W-1:0];
		r.tmp = tq[TMP_W-1:0];
		return r;
	endfunction

	// Driver: take the accepted item into the predictor, then offer the next one
	always @(posedge clk or negedge arst_n) begin : tx_drive
		poll_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			held_temp = '0;
		end else begin
			if (in_valid && in_ready) begin
				polls_taken++;
				if (temp_ready)
					held_temp = temp_raw;
				if (pressure_ready)
					comp_q.push_back(compensate(held_temp, pressure_raw));
			end
			if (!in_valid || in_ready) begin
				if (poll_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = poll_q.pop_front();
					in_valid <= 1'b1;
					temp_ready <= nxt.t_rdy;
					temp_raw <= nxt.t_raw;
					pressure_ready <= nxt.p_rdy;
					pressure_raw <= nxt.p_raw;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : rx_check
		comp_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (comp_q.size() == 0) begin
					flag("result with no prediction waiting");
				end else begin
					want = comp_q.pop_front();
					if (want.sat)
						sat_seen++;
					if (pressure_comp !== want.prs)
						flag($sformatf("pressure_comp %0d, predicted %0d",
							pressure_comp, want.prs));
					if (temperature_comp !== want.tmp)
						flag($sformatf("temperature_comp %0d, predicted %0d",
							temperature_comp, want.tmp));
					if (saturated !== want.sat)
						flag($sformatf("saturated %b, predicted %b", saturated, want.sat));
				end
			end
			out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic queue_poll(input logic t_rdy, input logic signed [RAW_W-1:0] t_raw,
			input logic p_rdy, input logic signed [RAW_W-1:0] p_raw);
		poll_t p;
		p.t_rdy = t_rdy;
		p.t_raw = t_raw;
		p.p_rdy = p_rdy;
		p.p_raw = p_raw;
		poll_q.push_back(p);
		polls_queued++;
	endtask

	// Wait for every poll to be taken and every result to arrive, then let
	// a temperature-only poll finish its cycle
	task automatic drain();
		while (polls_taken != polls_queued || comp_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		case (idx)
			REG_P_OFFSET: k_p_offset = v[19:0];
			REG_P_LINEAR: k_p_linear = v[19:0];
			REG_P_SQUARE: k_p_square = v[15:0];
			REG_P_CUBE:   k_p_cube = v[15:0];
			REG_T_TERM:   k_t_term = v[15:0];
			REG_X_LINEAR: k_x_linear = v[15:0];
			REG_X_SQUARE: k_x_square = v[15:0];
			REG_T_COEFS:  k_t_coefs = v;
			default: ;
		endcase
	endtask

	// Write all eight registers on consecutive edges; call only while idle
	task automatic load_coefs();
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= coef_set[i];
			apply_reg(IDX_W'(i), coef_set[i]);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_coef(int w);
		logic [CFG_W-1:0] small_v;
		small_v = CFG_W'($urandom_range(255));
		case ($urandom_range(4))
			0: return CFG_W'(1) << (w - 1);
			1: return (CFG_W'(1) << (w - 1)) - 1;
			2: return $urandom_range(1) ? -small_v : small_v;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [RAW_W-1:0] rand_raw();
		logic signed [RAW_W-1:0] small_v;
		small_v = RAW_W'($urandom_range(4095));
		case ($urandom_range(5))
			0: return RAW_MAX;
			1: return RAW_MIN;
			2: return $urandom_range(1) ? -small_v : small_v;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	task automatic directed_set();
		queue_poll(1'b0, '0, 1'b1, '0);
		queue_poll(1'b0, '0, 1'b1, RAW_MAX);
		queue_poll(1'b1, RAW_MAX, 1'b0, RAW_MIN);
		queue_poll(1'b0, '0, 1'b1, RAW_MIN);
		queue_poll(1'b1, RAW_MIN, 1'b1, RAW_MAX);
		queue_poll(1'b1, 24'sd1, 1'b1, -24'sd1);
		queue_poll(1'b0, RAW_MAX, 1'b0, RAW_MAX);
		queue_poll(1'b1, -24'sd1, 1'b1, 24'sd1);
		drain();
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Largest positive coefficients; the first poll sees no temperature yet
		coef_set[REG_P_OFFSET] = 24'h07FFFF;
		coef_set[REG_P_LINEAR] = 24'h07FFFF;
		coef_set[REG_P_SQUARE] = 24'h007FFF;
		coef_set[REG_P_CUBE]   = 24'h007FFF;
		coef_set[REG_T_TERM]   = 24'h007FFF;
		coef_set[REG_X_LINEAR] = 24'h007FFF;
		coef_set[REG_X_SQUARE] = 24'h007FFF;
		coef_set[REG_T_COEFS]  = 24'h7FF7FF;
		load_coefs();
		directed_set();

		// Most negative coefficients, with junk above the narrow fields
		coef_set[REG_P_OFFSET] = 24'hF80000;
		coef_set[REG_P_LINEAR] = 24'hA80000;
		coef_set[REG_P_SQUARE] = 24'hFF8000;
		coef_set[REG_P_CUBE]   = 24'h5A8000;
		coef_set[REG_T_TERM]   = 24'hC38000;
		coef_set[REG_X_LINEAR] = 24'hFF8000;
		coef_set[REG_X_SQUARE] = 24'h118000;
		coef_set[REG_T_COEFS]  = 24'h800800;
		load_coefs();
		directed_set();

		for (int phase = 0; phase < 6; phase++) begin
			coef_set[REG_P_OFFSET] = rand_coef(20);
			coef_set[REG_P_LINEAR] = rand_coef(20);
			coef_set[REG_P_SQUARE] = rand_coef(16);
			coef_set[REG_P_CUBE]   = rand_coef(16);
			coef_set[REG_T_TERM]   = rand_coef(16);
			coef_set[REG_X_LINEAR] = rand_coef(16);
			coef_set[REG_X_SQUARE] = rand_coef(16);
			coef_set[REG_T_COEFS]  = CFG_W'($urandom);
			load_coefs();
			// One phase runs with no idling on either side
			tx_idle_pct = (phase == 2) ? 0 : 27;
			rx_idle_pct = (phase == 2) ? 0 : 27;
			for (int n = 0; n < 230; n++)
				queue_poll(1'($urandom_range(1)), rand_raw(),
					($urandom_range(99) < 65), rand_raw());
			if (phase == 4) begin
				// Hold the output side off so the core backs up into its input
				rx_hold = 1'b1;
				repeat (600) @(negedge clk);
				rx_hold = 1'b0;
			end
			drain();
		end

		if (comp_q.size() != 0)
			flag($sformatf("%0d predictions never matched by a result", comp_q.size()));
		$display("ran %0d polls in %0d cycles: %0d results checked, %0d saturated",
			polls_taken, cycle_count, results_seen, sat_seen);
		$display("coefficient sets: two extremes and six random; %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("** baro_pressure_temp_compensate_core: PASSED **");
		else
			$display("** baro_pressure_temp_compensate_core: FAILED **");
		$finish;
	end

endmodule
